>>> sv/tree_lca_path_distance_core_macros.svh
`ifndef TREE_LCA_PATH_DISTANCE_CORE_MACROS_SVH
`define TREE_LCA_PATH_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tlpd_pkg.sv
package tlpd_pkg;

    localparam int NODE_W      = 10;
    localparam int WEIGHT_W    = 32;
    localparam int DIST_W      = 48;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - NODE_W - DIST_W;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
    localparam logic ERR_OK     = 1'b0;
    localparam logic ERR_REJECT = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_B,
        S_CHECK,
        S_FILL,
        S_FILL_END,
        S_LIFT,
        S_LIFT_END,
        S_JUMP,
        S_JUMP_END,
        S_LCA,
        S_DIST,
        S_OUT
    } t_state;

endpackage

>>> sv/tlpd_node_ram.sv
module tlpd_node_ram
    import tlpd_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 59
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tlpd_anc_ram.sv
module tlpd_anc_ram
    import tlpd_pkg::*;
#(
    parameter int NODES = 1024,
    parameter int IDX_W = 10,
    parameter int LVL_W = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_wnode,
    input  logic [LVL_W-1:0] i_wlvl,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_r0_node,
    input  logic [LVL_W-1:0] i_r0_lvl,
    input  logic [IDX_W-1:0] i_r1_node,
    input  logic [LVL_W-1:0] i_r1_lvl,
    output logic [IDX_W-1:0] o_r0_data,
    output logic [IDX_W-1:0] o_r1_data
);

    localparam int DEPTH = NODES * (2 ** LVL_W);

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] r_r0_data;
    logic [IDX_W-1:0] r_r1_data;

    // The sentinel node has no stored row; every one of its ancestors is the sentinel.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[{i_wnode, i_wlvl}] <= i_wdata;
        end
        if (i_r0_node == '0) begin
            r_r0_data <= '0;
        end else begin
            r_r0_data <= mem[{i_r0_node, i_r0_lvl}];
        end
        if (i_r1_node == '0) begin
            r_r1_data <= '0;
        end else begin
            r_r1_data <= mem[{i_r1_node, i_r1_lvl}];
        end
    end

    assign o_r0_data = r_r0_data;
    assign o_r1_data = r_r1_data;

endmodule

>>> sv/tree_lca_path_distance_core.sv
// Weighted tree store with lowest common ancestor and path length queries by binary lifting.
// A load transaction attaches node_a under node_b (or as a root when node_b is 0) and fills
// its ancestor levels one after another, since each level is a dependent read of the
// ancestor memory. A query transaction makes one pass over the levels to lift the deeper
// node, skips the second pass when one node is an ancestor of the other, and otherwise
// reads both ancestor rows per level in a second pass; then the common ancestor's distance
// is read and combined, unless the nodes lie in different trees. A transaction rejected at
// the first check goes straight to the output. After reset the node memory is cleared,
// during which no transaction is accepted. Results wait in an output register, so the next
// transaction is accepted while a result is still pending.
module tree_lca_path_distance_core
    import tlpd_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // node_a [9:0], node_b [19:10], edge_weight [51:20], zero padding [55:52]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type [0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // ancestor_node [9:0], path_distance [57:10], zero padding [63:58]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // error_code [0]
    output logic                   o_m_axis_tuser
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LVL_W = $clog2(LIFT_LEVELS);
    localparam int DEP_W = LIFT_LEVELS;
    localparam int ENT_W = 1 + DEP_W + DIST_W;
    localparam int SUM_W = DIST_W + 2;

    t_state r_state, n_state;

    logic [IDX_W-1:0]        r_clr;
    logic                    r_type;
    logic [NODE_W-1:0]       r_a;
    logic [NODE_W-1:0]       r_b;
    logic signed [WEIGHT_W-1:0] r_w;
    logic [ENT_W-1:0]        r_ent_a;
    logic [IDX_W-1:0]        r_u;
    logic [IDX_W-1:0]        r_v;
    logic [IDX_W-1:0]        r_cur;
    logic [LVL_W-1:0]        r_lvl;
    logic                    r_pend;
    logic [DEP_W-1:0]        r_diff;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_res_dist;
    logic [NODE_W-1:0]       r_res_anc;
    logic                    r_res_err;
    logic                    r_out_valid;
    logic [NODE_W-1:0]       r_out_anc;
    logic [DIST_W-1:0]       r_out_dist;
    logic                    r_out_err;

    logic                    nd_we;
    logic [IDX_W-1:0]        nd_waddr;
    logic [ENT_W-1:0]        nd_wdata;
    logic [IDX_W-1:0]        nd_raddr;
    logic [ENT_W-1:0]        nd_rdata;
    logic                    an_we;
    logic [IDX_W-1:0]        an_wnode;
    logic [LVL_W-1:0]        an_wlvl;
    logic [IDX_W-1:0]        an_wdata;
    logic [IDX_W-1:0]        an_r0_node;
    logic [LVL_W-1:0]        an_r0_lvl;
    logic [IDX_W-1:0]        an_r1_node;
    logic [LVL_W-1:0]        an_r1_lvl;
    logic [IDX_W-1:0]        ard0;
    logic [IDX_W-1:0]        ard1;

    logic                    s_ready;
    logic                    out_free;
    logic [IDX_W-1:0]        a_idx;
    logic [IDX_W-1:0]        b_idx;
    logic                    a_in;
    logic                    b_in;
    logic                    ent_a_loaded;
    logic [DEP_W-1:0]        ent_a_depth;
    logic signed [DIST_W-1:0] ent_a_dist;
    logic                    ent_b_loaded;
    logic [DEP_W-1:0]        ent_b_depth;
    logic signed [DIST_W-1:0] ent_b_dist;
    logic                    a_ok_load;
    logic                    b_ok_load;
    logic                    q_ok;
    logic [DEP_W-1:0]        new_depth;
    logic signed [DIST_W-1:0] new_dist;
    logic [IDX_W-1:0]        fill_cur;
    logic [IDX_W-1:0]        lift_u;
    logic                    jump_diff;
    logic [IDX_W-1:0]        jump_u;
    logic [IDX_W-1:0]        jump_v;
    logic [2:0]              res_top;
    logic [DIST_W-1:0]       sat_dist;

    tlpd_node_ram #(
        .DEPTH(MAX_NODES),
        .AW   (IDX_W),
        .DW   (ENT_W)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (nd_we),
        .i_waddr(nd_waddr),
        .i_wdata(nd_wdata),
        .i_raddr(nd_raddr),
        .o_rdata(nd_rdata)
    );

    tlpd_anc_ram #(
        .NODES(MAX_NODES),
        .IDX_W(IDX_W),
        .LVL_W(LVL_W)
    ) u_anc_ram (
        .i_clk    (i_clk),
        .i_we     (an_we),
        .i_wnode  (an_wnode),
        .i_wlvl   (an_wlvl),
        .i_wdata  (an_wdata),
        .i_r0_node(an_r0_node),
        .i_r0_lvl (an_r0_lvl),
        .i_r1_node(an_r1_node),
        .i_r1_lvl (an_r1_lvl),
        .o_r0_data(ard0),
        .o_r1_data(ard1)
    );

    assign a_idx = IDX_W'(r_a);
    assign b_idx = IDX_W'(r_b);
    assign a_in  = 32'(r_a) < 32'(MAX_NODES);
    assign b_in  = 32'(r_b) < 32'(MAX_NODES);

    assign ent_a_loaded = r_ent_a[ENT_W-1];
    assign ent_a_depth  = r_ent_a[DIST_W +: DEP_W];
    assign ent_a_dist   = r_ent_a[DIST_W-1:0];
    assign ent_b_loaded = nd_rdata[ENT_W-1];
    assign ent_b_depth  = nd_rdata[DIST_W +: DEP_W];
    assign ent_b_dist   = nd_rdata[DIST_W-1:0];

    assign a_ok_load = (r_a != '0) && a_in && !ent_a_loaded;
    assign b_ok_load = (r_b == '0) || (b_in && ent_b_loaded && (ent_b_depth != '1));
    assign q_ok      = (r_a != '0) && a_in && ent_a_loaded
                    && (r_b != '0) && b_in && ent_b_loaded;

    assign new_depth = (r_b == '0) ? '0 : ent_b_depth + DEP_W'(1);
    assign new_dist  = ((r_b == '0) ? DIST_W'(0) : ent_b_dist) + DIST_W'(r_w);

    assign fill_cur  = r_pend ? ard0 : r_cur;
    assign lift_u    = r_pend ? ard0 : r_u;
    assign jump_diff = r_pend && (ard0 != ard1);
    assign jump_u    = jump_diff ? ard0 : r_u;
    assign jump_v    = jump_diff ? ard1 : r_v;

    assign out_free = !r_out_valid || i_m_axis_tready;

    assign res_top = r_res_dist[SUM_W-1:DIST_W-1];
    always_comb begin
        if ((res_top == '0) || (res_top == '1)) begin
            sat_dist = r_res_dist[DIST_W-1:0];
        end else if (r_res_dist[SUM_W-1]) begin
            sat_dist = DIST_MIN;
        end else begin
            sat_dist = DIST_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        s_ready    = 1'b0;
        nd_we      = 1'b0;
        nd_waddr   = a_idx;
        nd_wdata   = {1'b1, new_depth, new_dist};
        nd_raddr   = b_idx;
        an_we      = 1'b0;
        an_wnode   = a_idx;
        an_wlvl    = '0;
        an_wdata   = ard0;
        an_r0_node = '0;
        an_r0_lvl  = '0;
        an_r1_node = '0;
        an_r1_lvl  = '0;
        case (r_state)
            S_CLEAR: begin
                nd_we    = 1'b1;
                nd_waddr = r_clr;
                nd_wdata = '0;
                if (r_clr == IDX_W'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                nd_raddr = IDX_W'(i_s_axis_tdata[NODE_W-1:0]);
                if (i_s_axis_tvalid) begin
                    n_state = S_RD_B;
                end
            end
            S_RD_B: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_type == REQ_LOAD) begin
                    if (a_ok_load && b_ok_load) begin
                        nd_we    = 1'b1;
                        an_we    = 1'b1;
                        an_wdata = b_idx;
                        n_state  = S_FILL;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (q_ok) begin
                    n_state = S_LIFT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FILL: begin
                an_we      = r_pend;
                an_wlvl    = r_lvl - LVL_W'(1);
                an_r0_node = fill_cur;
                an_r0_lvl  = r_lvl - LVL_W'(1);
                if (r_lvl == LVL_W'(LIFT_LEVELS - 1)) begin
                    n_state = S_FILL_END;
                end
            end
            S_FILL_END: begin
                an_we   = 1'b1;
                an_wlvl = LVL_W'(LIFT_LEVELS - 1);
                n_state = S_OUT;
            end
            S_LIFT: begin
                an_r0_node = lift_u;
                an_r0_lvl  = r_lvl;
                if (r_lvl == LVL_W'(LIFT_LEVELS - 1)) begin
                    n_state = S_LIFT_END;
                end
            end
            S_LIFT_END: begin
                if (lift_u == r_v) begin
                    nd_raddr = lift_u;
                    n_state  = S_DIST;
                end else begin
                    n_state = S_JUMP;
                end
            end
            S_JUMP: begin
                an_r0_node = jump_u;
                an_r0_lvl  = r_lvl;
                an_r1_node = jump_v;
                an_r1_lvl  = r_lvl;
                if (r_lvl == '0) begin
                    n_state = S_JUMP_END;
                end
            end
            S_JUMP_END: begin
                an_r0_node = jump_u;
                n_state    = S_LCA;
            end
            S_LCA: begin
                if (ard0 == '0) begin
                    n_state = S_OUT;
                end else begin
                    nd_raddr = ard0;
                    n_state  = S_DIST;
                end
            end
            S_DIST: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    r_type <= i_s_axis_tuser;
                    r_a    <= i_s_axis_tdata[NODE_W-1:0];
                    r_b    <= i_s_axis_tdata[2*NODE_W-1:NODE_W];
                    r_w    <= i_s_axis_tdata[2*NODE_W +: WEIGHT_W];
                end
            end
            S_RD_B: begin
                r_ent_a <= nd_rdata;
            end
            S_CHECK: begin
                r_res_dist <= '0;
                r_res_err  <= ERR_REJECT;
                r_pend     <= 1'b0;
                r_cur      <= b_idx;
                r_sum      <= SUM_W'(ent_a_dist) + SUM_W'(ent_b_dist);
                if (r_type == REQ_LOAD) begin
                    r_res_anc <= r_a;
                    r_lvl     <= LVL_W'(1);
                    if (a_ok_load && b_ok_load) begin
                        r_res_err <= ERR_OK;
                    end
                end else begin
                    r_res_anc <= '0;
                    r_lvl     <= '0;
                    if (ent_a_depth >= ent_b_depth) begin
                        r_u    <= a_idx;
                        r_v    <= b_idx;
                        r_diff <= ent_a_depth - ent_b_depth;
                    end else begin
                        r_u    <= b_idx;
                        r_v    <= a_idx;
                        r_diff <= ent_b_depth - ent_a_depth;
                    end
                end
            end
            S_FILL: begin
                r_pend <= 1'b1;
                r_cur  <= fill_cur;
                r_lvl  <= r_lvl + LVL_W'(1);
            end
            S_LIFT: begin
                r_u    <= lift_u;
                r_pend <= r_diff[r_lvl];
                r_lvl  <= r_lvl + LVL_W'(1);
            end
            S_LIFT_END: begin
                r_u    <= lift_u;
                r_pend <= 1'b0;
                r_lvl  <= LVL_W'(LIFT_LEVELS - 1);
                if (lift_u == r_v) begin
                    r_res_anc <= NODE_W'(lift_u);
                    r_res_err <= ERR_OK;
                end
            end
            S_JUMP: begin
                r_u    <= jump_u;
                r_v    <= jump_v;
                r_pend <= 1'b1;
                r_lvl  <= r_lvl - LVL_W'(1);
            end
            S_LCA: begin
                if (ard0 != '0) begin
                    r_res_anc <= NODE_W'(ard0);
                    r_res_err <= ERR_OK;
                end
            end
            S_DIST: begin
                r_res_dist <= r_sum - (SUM_W'(ent_b_dist) <<< 1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_anc  <= r_res_anc;
            r_out_dist <= sat_dist;
            r_out_err  <= r_res_err;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_dist, r_out_anc};
    assign o_m_axis_tuser  = r_out_err;

endmodule

>>> sv/tlpd_checker.sv
`include "tree_lca_path_distance_core_macros.svh"

module tlpd_checker
    import tlpd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser
);

    `TLPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "Result dropped while stalled.")
    `TLPD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "Result changed while stalled.")
    `TLPD_ASSERT_NOW(a_err_no_dist, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == ERR_REJECT), o_m_axis_tdata[NODE_W +: DIST_W] == '0, "Rejected transaction carries a distance.")
    `TLPD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "Transaction accepted while another is in progress.")

endmodule

bind tree_lca_path_distance_core tlpd_checker u_tlpd_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench
    import tlpd_pkg::*;
();

    localparam int     TREE_NODES   = 1024;
    localparam int     LIFT_LEVELS  = 10;
    localparam int     DEEPEST      = (1 << LIFT_LEVELS) - 1;
    localparam int     RANDOM_ITEMS = 700;
    localparam int     RUN_LIMIT    = 500000;
    localparam int     FLUSH_CYCLES = 40;
    localparam int     LONG_HOLD    = 300;
    localparam longint DIST_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DIST_LO      = -DIST_HI - 1;

    typedef struct {
        logic                req;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        bit                  wait_idle;
    } t_tree_request;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] path_len;
        logic              err;
    } t_tree_answer;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic                   s_user  = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_user;

    t_tree_request requests_to_send[$];
    t_tree_answer  awaited_results[$];

    logic [10:0]       tree_depth   [TREE_NODES];
    longint            tree_dist    [TREE_NODES];
    logic [NODE_W-1:0] tree_up      [TREE_NODES][LIFT_LEVELS];
    bit                tree_present [TREE_NODES];

    logic in_fire = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;
    int   hold_off_left = 0;
    bit   long_hold_done = 1'b0;

    tree_lca_path_distance_core #(
        .MAX_NODES   (TREE_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] x,
                                                          input logic [NODE_W-1:0] y);
        logic [NODE_W-1:0] deep;
        logic [NODE_W-1:0] shallow;
        logic [10:0]       climb;
        deep    = x;
        shallow = y;
        if (tree_depth[x] < tree_depth[y]) begin
            deep    = y;
            shallow = x;
        end
        climb = tree_depth[deep] - tree_depth[shallow];
        for (int j = 0; j < LIFT_LEVELS; j++) begin
            if (climb[j]) begin
                deep = tree_up[deep][j];
            end
        end
        if (deep == shallow) begin
            return deep;
        end
        for (int j = LIFT_LEVELS - 1; j >= 0; j--) begin
            if (tree_up[deep][j] != tree_up[shallow][j]) begin
                deep    = tree_up[deep][j];
                shallow = tree_up[shallow][j];
            end
        end
        return tree_up[deep][0];
    endfunction

    function automatic t_tree_answer tree_step(input t_tree_request r);
        t_tree_answer      ans;
        logic [10:0]       new_depth;
        longint            new_dist;
        longint            span;
        logic [NODE_W-1:0] top;
        bit                ok;
        new_depth = '0;
        new_dist  = 0;
        if (r.req == REQ_LOAD) begin
            ans.node     = r.node_a;
            ans.path_len = '0;
            ans.err      = ERR_REJECT;
            ok = (r.node_a != '0) && !tree_present[r.node_a];
            if (ok && r.node_b == '0) begin
                new_dist = longint'($signed(r.weight));
            end else if (ok && tree_present[r.node_b] && tree_depth[r.node_b] < DEEPEST) begin
                new_depth = tree_depth[r.node_b] + 11'd1;
                new_dist  = tree_dist[r.node_b] + longint'($signed(r.weight));
            end else begin
                ok = 1'b0;
            end
            if (ok) begin
                tree_depth[r.node_a] = new_depth;
                tree_dist[r.node_a]  = new_dist;
                tree_up[r.node_a][0] = r.node_b;
                for (int j = 1; j < LIFT_LEVELS; j++) begin
                    tree_up[r.node_a][j] = tree_up[tree_up[r.node_a][j-1]][j-1];
                end
                tree_present[r.node_a] = 1'b1;
                ans.err = ERR_OK;
            end
        end else begin
            ans.node     = '0;
            ans.path_len = '0;
            ans.err      = ERR_REJECT;
            if (r.node_a != '0 && r.node_b != '0 && tree_present[r.node_a]
                && tree_present[r.node_b]) begin
                top = common_ancestor(r.node_a, r.node_b);
                if (top != '0) begin
                    span = tree_dist[r.node_a] + tree_dist[r.node_b] - 2 * tree_dist[top];
                    if (span > DIST_HI) begin
                        span = DIST_HI;
                    end
                    if (span < DIST_LO) begin
                        span = DIST_LO;
                    end
                    ans.node     = top;
                    ans.path_len = span[DIST_W-1:0];
                    ans.err      = ERR_OK;
                end
            end
        end
        return ans;
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        logic [WEIGHT_W-1:0] w;
        if ($urandom_range(0, 1) == 0) begin
            w = $urandom;
        end else begin
            w = $urandom_range(0, 4000) - 2000;
        end
        return w;
    endfunction

    task automatic add_load(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                            input logic [WEIGHT_W-1:0] w, input bit hold);
        t_tree_request r;
        r.req       = REQ_LOAD;
        r.node_a    = a;
        r.node_b    = b;
        r.weight    = w;
        r.wait_idle = hold;
        requests_to_send = {requests_to_send, r};
    endtask

    task automatic add_query(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                             input bit hold);
        t_tree_request r;
        r.req       = REQ_QUERY;
        r.node_a    = a;
        r.node_b    = b;
        r.weight    = $urandom;
        r.wait_idle = hold;
        requests_to_send = {requests_to_send, r};
    endtask

    task automatic build_stimulus();
        logic [NODE_W-1:0] free_ids[$];
        logic [NODE_W-1:0] grown_ids[$];
        logic [NODE_W-1:0] chain_tip;
        logic [NODE_W-1:0] fresh;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] qa;
        logic [NODE_W-1:0] qb;
        logic [NODE_W-1:0] swap;
        int                k;
        int                pick;
        int                route;
        bit                hold;

        add_query(10'd0, 10'd0, 1'b0);
        add_query(10'd5, 10'd7, 1'b0);
        add_load(10'd0, 10'd0, 32'd5, 1'b0);
        add_load(10'd4, 10'd9, 32'd17, 1'b0);
        add_load(10'd1, 10'd0, 32'h7FFF_FFFF, 1'b0);
        add_load(10'd2, 10'd1, 32'h8000_0000, 1'b0);
        add_load(10'd1023, 10'd2, 32'hFFFF_FFFF, 1'b0);
        add_load(10'd1, 10'd0, 32'd3, 1'b0);
        add_load(10'd1, 10'd1023, 32'd3, 1'b0);
        add_load(10'd3, 10'd0, 32'd0, 1'b1);
        add_query(10'd1023, 10'd3, 1'b0);
        add_query(10'd1023, 10'd1023, 1'b0);
        add_query(10'd1023, 10'd1, 1'b0);
        add_query(10'd2, 10'd1023, 1'b0);
        add_query(10'd1, 10'd0, 1'b0);
        add_query(10'd0, 10'd1023, 1'b0);
        add_query(10'd3, 10'd4, 1'b0);
        add_query(10'd1023, 10'd2, 1'b0);
        add_load(10'd1023, 10'd0, 32'h5555_AAAA, 1'b0);
        add_query(10'd3, 10'd3, 1'b0);

        for (int n = 4; n < TREE_NODES - 1; n++) begin
            free_ids = {free_ids, n[NODE_W-1:0]};
        end
        for (int n = free_ids.size() - 1; n > 0; n--) begin
            k = $urandom_range(0, n);
            swap        = free_ids[n];
            free_ids[n] = free_ids[k];
            free_ids[k] = swap;
        end
        grown_ids = '{10'd1, 10'd2, 10'd3, 10'd1023};
        chain_tip = 10'd1023;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            hold = (n % 175 == 0);
            pick = $urandom_range(0, 99);
            qa   = grown_ids[$urandom_range(0, grown_ids.size() - 1)];
            qb   = grown_ids[$urandom_range(0, grown_ids.size() - 1)];
            if (pick < 60 && free_ids.size() > 1) begin
                fresh = free_ids.pop_front();
                route = $urandom_range(0, 99);
                if (route < 85) begin
                    parent = chain_tip;
                end else if (route < 95) begin
                    parent = qa;
                end else begin
                    parent = '0;
                end
                add_load(fresh, parent, random_weight(), hold);
                if (route < 85) begin
                    chain_tip = fresh;
                end
                grown_ids = {grown_ids, fresh};
            end else if (pick < 92) begin
                if ($urandom_range(0, 9) == 0) begin
                    qb = qa;
                end
                add_query(qa, qb, hold);
            end else begin
                case ($urandom_range(0, 4))
                    0: add_load(qa, qb, random_weight(), hold);
                    1: add_load(free_ids[0], free_ids[free_ids.size() - 1], $urandom, hold);
                    2: add_load('0, qb, $urandom, hold);
                    3: add_query(free_ids[0], qb, hold);
                    default: add_query(NODE_W'($urandom_range(0, TREE_NODES - 1)), qb, hold);
                endcase
            end
        end
    endtask

    always @(negedge i_clk) begin
        t_tree_request next_req;
        if (i_rst_n && (in_fire || !s_valid)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (requests_to_send.size() == 0
                         || (requests_to_send[0].wait_idle && awaited_results.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                next_req = requests_to_send.pop_front();
                s_data  <= {{(IN_TDATA_W - 2 * NODE_W - WEIGHT_W){1'b0}},
                            next_req.weight, next_req.node_b, next_req.node_a};
                s_user  <= next_req.req;
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 250) begin
            long_hold_done = 1'b1;
            hold_off_left  = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(5, 60);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'b0;
                default: m_ready <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_tree_answer  got;
        t_tree_answer  want;
        t_tree_request seen;
        in_fire <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && m_valid && m_ready) begin
            got.node     = m_data[NODE_W-1:0];
            got.path_len = m_data[NODE_W +: DIST_W];
            got.err      = m_user;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t ns: result with nothing outstanding, expected none, %s %0d/%0d/%0d",
                         $time, "actual", got.node, $signed(got.path_len), got.err);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (got.node !== want.node) begin
                    $display("%0t ns: ancestor_node mismatch, expected %0d, actual %0d",
                             $time, want.node, got.node);
                    mismatches++;
                end
                if (got.path_len !== want.path_len) begin
                    $display("%0t ns: path_distance mismatch, expected %0d, actual %0d",
                             $time, $signed(want.path_len), $signed(got.path_len));
                    mismatches++;
                end
                if (got.err !== want.err) begin
                    $display("%0t ns: error_code mismatch, expected %0d, actual %0d",
                             $time, want.err, got.err);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && s_valid && s_ready) begin
            seen.req       = s_user;
            seen.node_a    = s_data[NODE_W-1:0];
            seen.node_b    = s_data[NODE_W +: NODE_W];
            seen.weight    = s_data[2 * NODE_W +: WEIGHT_W];
            seen.wait_idle = 1'b0;
            awaited_results = {awaited_results, tree_step(seen)};
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int n = 0; n < TREE_NODES; n++) begin
            tree_depth[n]   = '0;
            tree_dist[n]    = 0;
            tree_present[n] = 1'b0;
            for (int j = 0; j < LIFT_LEVELS; j++) begin
                tree_up[n][j] = '0;
            end
        end
        build_stimulus();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (requests_to_send.size() != 0 || s_valid) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
